### rtl/core/pdt_pkg.sv
// Shared types and constants for the prescaled dual timer.
`timescale 1ns / 1ps

package pdt_pkg;

	localparam int unsigned NUM_TIMERS     = 2;
	localparam int unsigned NUM_TICK_PINS  = 2;
	localparam int unsigned NUM_CLEAR_PINS = 2;
	localparam int unsigned PRESC_BITS     = 16;
	localparam int unsigned OVF_BITS       = 16;
	localparam int unsigned OUT_CNT_BITS   = 16;
	localparam int unsigned TICK_EN_BITS   = NUM_TICK_PINS + 1;
	localparam int unsigned APB_DATA_BITS  = 32;
	localparam int unsigned APB_ADDR_BITS  = 5;

	// Register map, word index (byte address / 4)
	typedef enum logic [2:0] {
		REG_PRESC_LIMIT = 3'd0,
		REG_T0_TICK_EN  = 3'd1,
		REG_T0_CLR_EN   = 3'd2,
		REG_T0_OVF      = 3'd3,
		REG_T1_TICK_EN  = 3'd4,
		REG_T1_CLR_EN   = 3'd5,
		REG_T1_OVF      = 3'd6
	} reg_idx_t;

	typedef logic [TICK_EN_BITS-1:0]   tick_en_t;
	typedef logic [NUM_CLEAR_PINS-1:0] clr_en_t;
	typedef logic [OVF_BITS-1:0]       ovf_t;

endpackage

### rtl/core/prescaled_dual_timer.sv
// Top level of the prescaled dual timer: prescaler, two compare timers, register port.
`timescale 1ns / 1ps

// Channel  | Handshake                    | Beat contents
// ---------+------------------------------+------------------------------------------
// in       | in_valid / in_stall          | ext_tick_edges, ext_clear_edges
// out      | out_valid / out_stall        | t0_count, t1_count, t0_irq, t1_irq, presc_tick
// apb      | psel, penable, pwrite, pready| paddr, pwdata, prdata (registers at 4*index)
//
// Each input beat is one timer cycle. A beat is held in the input register and
// then lands in the result register, and one beat is taken every cycle while
// the result side keeps up.
// arst_n clears the prescaler, both timer counts, all configuration registers and valid flags.
// When out_stall holds the result register, the input register holds too and
// in_stall rises only once the input register is also occupied.
module prescaled_dual_timer
	import pdt_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [NUM_TICK_PINS-1:0] ext_tick_edges,
	input  logic [NUM_CLEAR_PINS-1:0] ext_clear_edges,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [OUT_CNT_BITS-1:0]  t0_count,
	output logic [OUT_CNT_BITS-1:0]  t1_count,
	output logic                     t0_irq,
	output logic                     t1_irq,
	output logic                     presc_tick,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	// Compare width: holds count + 1 and the full overflow register
	localparam int unsigned CMP_W = ((COUNT_BITS > OVF_BITS) ? COUNT_BITS : OVF_BITS) + 1;
	localparam logic [CMP_W-1:0] CNT_MASK_W = CMP_W'({COUNT_BITS{1'b1}});
	localparam logic [OVF_BITS-1:0] OVF_MASK = CNT_MASK_W[OVF_BITS-1:0];

	// Configuration registers
	logic [PRESC_BITS-1:0] presc_limit_q;
	tick_en_t              tick_en_q [NUM_TIMERS];
	clr_en_t               clr_en_q  [NUM_TIMERS];
	ovf_t                  ovf_q     [NUM_TIMERS];

	// Timer state
	logic [PRESC_BITS-1:0] presc_cnt_q;
	logic [COUNT_BITS-1:0] cnt_q [NUM_TIMERS];

	// Input register
	logic                      valid_s1;
	logic [NUM_TICK_PINS-1:0]  ticks_s1;
	logic [NUM_CLEAR_PINS-1:0] clears_s1;

	// Result register
	logic                    out_valid_q;
	logic [OUT_CNT_BITS-1:0] t0_count_q;
	logic [OUT_CNT_BITS-1:0] t1_count_q;
	logic                    t0_irq_q;
	logic                    t1_irq_q;
	logic                    presc_tick_q;

	// Next-state logic
	logic                  advance;
	logic                  presc_hit;
	logic [PRESC_BITS-1:0] presc_cnt_nxt;
	logic [COUNT_BITS-1:0] cnt_nxt [NUM_TIMERS];
	logic                  irq_nxt [NUM_TIMERS];
	logic [CMP_W-1:0]      cnt_wide [NUM_TIMERS];

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	// Move the input beat on when the result register is empty or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
	assign pready  = 1'b1;

	// Prescaler: tick and restart once the count is at or past the limit
	always_comb begin
		presc_hit     = (presc_cnt_q >= presc_limit_q);
		presc_cnt_nxt = presc_hit ? '0 : presc_cnt_q + 1'b1;
	end

	// Timers: clear beats tick; wrap and interrupt once count + 1 reaches or passes the overflow value
	always_comb begin
		logic             do_clear;
		logic             do_tick;
		logic [CMP_W-1:0] inc;
		logic [CMP_W-1:0] ovf_w;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			do_clear = |(clr_en_q[t] & clears_s1);
			do_tick  = (presc_hit && tick_en_q[t][0]) ||
				(|(tick_en_q[t][TICK_EN_BITS-1:1] & ticks_s1));
			inc      = CMP_W'(cnt_q[t]) + 1'b1;
			ovf_w    = CMP_W'(ovf_q[t]);
			cnt_nxt[t] = cnt_q[t];
			irq_nxt[t] = 1'b0;
			if (do_clear) begin
				cnt_nxt[t] = '0;
			end else if (do_tick) begin
				if (inc >= ovf_w) begin
					cnt_nxt[t] = '0;
					irq_nxt[t] = 1'b1;
				end else begin
					cnt_nxt[t] = inc[COUNT_BITS-1:0];
				end
			end
			cnt_wide[t] = CMP_W'(cnt_nxt[t]);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ticks_s1  <= ext_tick_edges;
			clears_s1 <= ext_clear_edges;
		end
	end

	// State and result register: commit one timer cycle per advanced beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			presc_cnt_q <= '0;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				presc_cnt_q <= presc_cnt_nxt;
				for (int t = 0; t < NUM_TIMERS; t++) begin
					cnt_q[t] <= cnt_nxt[t];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t0_count_q   <= cnt_wide[0][OUT_CNT_BITS-1:0];
			t1_count_q   <= cnt_wide[1][OUT_CNT_BITS-1:0];
			t0_irq_q     <= irq_nxt[0];
			t1_irq_q     <= irq_nxt[1];
			presc_tick_q <= presc_hit;
		end
	end

	assign out_valid  = out_valid_q;
	assign t0_count   = t0_count_q;
	assign t1_count   = t1_count_q;
	assign t0_irq     = t0_irq_q;
	assign t1_irq     = t1_irq_q;
	assign presc_tick = presc_tick_q;

	// Register writes; overflow values drop bits above the count width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_limit_q <= '0;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				tick_en_q[t] <= '0;
				clr_en_q[t]  <= '0;
				ovf_q[t]     <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PRESC_LIMIT: presc_limit_q <= pwdata[PRESC_BITS-1:0];
				REG_T0_TICK_EN:  tick_en_q[0]  <= pwdata[TICK_EN_BITS-1:0];
				REG_T0_CLR_EN:   clr_en_q[0]   <= pwdata[NUM_CLEAR_PINS-1:0];
				REG_T0_OVF:      ovf_q[0]      <= pwdata[OVF_BITS-1:0] & OVF_MASK;
				REG_T1_TICK_EN:  tick_en_q[1]  <= pwdata[TICK_EN_BITS-1:0];
				REG_T1_CLR_EN:   clr_en_q[1]   <= pwdata[NUM_CLEAR_PINS-1:0];
				REG_T1_OVF:      ovf_q[1]      <= pwdata[OVF_BITS-1:0] & OVF_MASK;
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (cfg_idx)
			REG_PRESC_LIMIT: prdata = APB_DATA_BITS'(presc_limit_q);
			REG_T0_TICK_EN:  prdata = APB_DATA_BITS'(tick_en_q[0]);
			REG_T0_CLR_EN:   prdata = APB_DATA_BITS'(clr_en_q[0]);
			REG_T0_OVF:      prdata = APB_DATA_BITS'(ovf_q[0]);
			REG_T1_TICK_EN:  prdata = APB_DATA_BITS'(tick_en_q[1]);
			REG_T1_CLR_EN:   prdata = APB_DATA_BITS'(clr_en_q[1]);
			REG_T1_OVF:      prdata = APB_DATA_BITS'(ovf_q[1]);
			default:         prdata = '0;
		endcase
	end

endmodule
